[sv/priority_round_robin_scheduler_top_assert.svh]
// Assertion helpers for the scheduler. They sample on the rising edge of clock
// and are switched off while reset is high.
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRRS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scheduler check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define PRRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("scheduler check failed one cycle later");

`endif

[sv/prrs_pkg.sv]
`timescale 1ns / 1ps

package prrs_pkg;

   // Default geometry of the slot table.
   localparam int SLOTS_DEF  = 16;
   localparam int LEVELS_DEF = 4;

   // Fixed field widths.
   localparam int TIME_W     = 16;
   localparam int OPCODE_W   = 1;
   localparam int JOB_SLOT_W = 4;
   localparam int PRIO_W     = 2;
   localparam int SVC_W      = 4;
   localparam int STATUS_W   = 2;

   // Register port geometry: one 32-bit register, word addressed.
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_LSB = 2;
   localparam logic [CSR_ADDR_W-CSR_IDX_LSB-1:0] REG_TIME_LIMIT = '0;

   localparam logic [TIME_W-1:0] TIME_LIMIT_RESET = 16'd300;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ARRIVAL = 1'b0,
      OP_TICK    = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_OCCUPIED = 2'd1,
      ST_OVERRUN  = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [JOB_SLOT_W-1:0] job_slot;
      logic [PRIO_W-1:0]     job_priority;
      logic [SVC_W-1:0]      service_ticks;
   } req_item_type;

   typedef struct packed {
      status_type            status;
      logic                  ran_valid;
      logic [JOB_SLOT_W-1:0] ran_slot;
      logic                  finished;
      logic [TIME_W-1:0]     response_ticks;
      logic [TIME_W-1:0]     turnaround_ticks;
      logic [TIME_W-1:0]     wait_ticks;
   } rsp_item_type;

endpackage

[sv/prrs_if.sv]
`timescale 1ns / 1ps

// Request channel: arrivals and ticks.
interface prrs_req_if;
   import prrs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OPCODE_W-1:0]   opcode;
   logic [JOB_SLOT_W-1:0] job_slot;
   logic [PRIO_W-1:0]     job_priority;
   logic [SVC_W-1:0]      service_ticks;

   modport source (output valid, output opcode, output job_slot, output job_priority,
                   output service_ticks, input ready);
   modport sink   (input valid, input opcode, input job_slot, input job_priority,
                   input service_ticks, output ready);
endinterface

// Response channel: one beat per request beat.
interface prrs_rsp_if;
   import prrs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic                  ran_valid;
   logic [JOB_SLOT_W-1:0] ran_slot;
   logic                  finished;
   logic [TIME_W-1:0]     response_ticks;
   logic [TIME_W-1:0]     turnaround_ticks;
   logic [TIME_W-1:0]     wait_ticks;

   modport source (output valid, output status, output ran_valid, output ran_slot,
                   output finished, output response_ticks, output turnaround_ticks,
                   output wait_ticks, input ready);
   modport sink   (input valid, input status, input ran_valid, input ran_slot,
                   input finished, input response_ticks, input turnaround_ticks,
                   input wait_ticks, output ready);
endinterface

[sv/priority_round_robin_scheduler_top.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Contents
// req_ch    in         valid/ready          opcode, job_slot, job_priority, service_ticks
// rsp_ch    out        valid/ready          status, ran info, completion times
// csr_*     in/out     APB, pready always   time_limit at byte address 0
//
// One beat is accepted per cycle while the response side is not stalled; its response
// passes through the input register, then the result register.
// The slot pick is a per-level rotating priority encoder evaluated in a single
// pass between the two registers, so ticks and arrivals can follow back to back.
// Reset is synchronous; it empties both registers and frees every slot.
// A stalled response holds the result register, and the input register keeps
// taking beats until it is also occupied.
`include "priority_round_robin_scheduler_top_assert.svh"

module priority_round_robin_scheduler_top #(
   parameter int SLOTS  = prrs_pkg::SLOTS_DEF,
   parameter int LEVELS = prrs_pkg::LEVELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   prrs_req_if.sink                        req_ch,
   prrs_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [prrs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [prrs_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [prrs_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import prrs_pkg::*;

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LVL_W  = $clog2(LEVELS);
   localparam logic [7:0]        SLOTS_CMP  = 8'(SLOTS);
   localparam logic [3:0]        LEVELS_CMP = 4'(LEVELS);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOTS - 1);
   localparam logic [LVL_W-1:0]  LAST_LVL   = LVL_W'(LEVELS - 1);

   // Lowest set bit of a slot vector.
   function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] v);
      logic [SLOT_W-1:0] r;
      r = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i]) r = SLOT_W'(i);
      end
      return r;
   endfunction

   // Pipeline registers.
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff, s1_item_in;
   logic         s2_valid_ff, s2_valid_in;
   rsp_item_type s2_item_ff, s2_item_in;

   // Scheduler state.
   logic [TIME_W-1:0] time_ff, time_in;
   logic [TIME_W-1:0] limit_ff, limit_in;
   logic [SLOTS-1:0]  slot_valid_ff, slot_valid_in;
   logic [SLOTS-1:0]  slot_started_ff, slot_started_in;
   logic [LVL_W-1:0]  slot_level_ff [SLOTS];
   logic [LVL_W-1:0]  slot_level_in [SLOTS];
   logic [SVC_W-1:0]  slot_remain_ff [SLOTS];
   logic [SVC_W-1:0]  slot_remain_in [SLOTS];
   logic [SVC_W-1:0]  slot_service_ff [SLOTS];
   logic [SVC_W-1:0]  slot_service_in [SLOTS];
   logic [TIME_W-1:0] slot_arrival_ff [SLOTS];
   logic [TIME_W-1:0] slot_arrival_in [SLOTS];
   logic [TIME_W-1:0] slot_start_ff [SLOTS];
   logic [TIME_W-1:0] slot_start_in [SLOTS];
   logic [SLOT_W-1:0] level_ptr_ff [LEVELS];
   logic [SLOT_W-1:0] level_ptr_in [LEVELS];

   logic advance, fire;

   // Handshake: the input register moves on whenever the result register is free or its response is taken.
   assign advance      = !s2_valid_ff || rsp_ch.ready;
   assign fire         = s1_valid_ff && advance;
   assign req_ch.ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_ch.ready) begin
         s1_valid_in              = req_ch.valid;
         s1_item_in.opcode        = opcode_type'(req_ch.opcode);
         s1_item_in.job_slot      = req_ch.job_slot;
         s1_item_in.job_priority  = req_ch.job_priority;
         s1_item_in.service_ticks = req_ch.service_ticks;
      end
   end

   // Rotating pick inside each level, then the lowest-numbered non-empty level.
   logic [SLOTS-1:0]  lvl_req   [LEVELS];
   logic [SLOT_W-1:0] lvl_pick  [LEVELS];
   logic [LEVELS-1:0] lvl_any;
   logic [SLOTS-1:0]  upper;
   logic [SLOT_W-1:0] pick;
   logic [LVL_W-1:0]  pick_lvl;
   logic              any_ready;

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         for (int s = 0; s < SLOTS; s++) begin
            lvl_req[l][s] = slot_valid_ff[s] && (slot_level_ff[s] == LVL_W'(l));
            upper[s]      = SLOT_W'(s) >= level_ptr_ff[l];
         end
         lvl_any[l]  = |lvl_req[l];
         lvl_pick[l] = (|(lvl_req[l] & upper)) ? first_set(lvl_req[l] & upper)
                                                : first_set(lvl_req[l]);
      end
      pick     = '0;
      pick_lvl = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (lvl_any[l]) begin
            pick     = lvl_pick[l];
            pick_lvl = LVL_W'(l);
         end
      end
      any_ready = |lvl_any;
   end

   // Tick arithmetic for the picked slot.
   logic              is_tick, overrun, done;
   logic [SVC_W-1:0]  rem_next;
   logic [TIME_W-1:0] time_next, start_val, resp_val, turn_val, wait_val;
   logic [SLOT_W-1:0] pick_next;

   assign is_tick   = s1_item_ff.opcode == OP_TICK;
   assign overrun   = time_ff > limit_ff;
   assign time_next = time_ff + 1'b1;
   assign rem_next  = slot_remain_ff[pick] - 1'b1;
   assign done      = rem_next == '0;
   assign start_val = slot_started_ff[pick] ? slot_start_ff[pick] : time_ff;
   assign resp_val  = start_val - slot_arrival_ff[pick];
   assign turn_val  = time_next - slot_arrival_ff[pick];
   assign wait_val  = turn_val - TIME_W'(slot_service_ff[pick]);
   assign pick_next = (pick == LAST_SLOT) ? '0 : pick + 1'b1;

   // Arrival decode: range check, level clamp and zero service fix-up.
   logic              occupied;
   logic [SLOT_W-1:0] arr_idx;
   logic [LVL_W-1:0]  arr_lvl;
   logic [SVC_W-1:0]  arr_svc;

   assign arr_idx  = SLOT_W'(s1_item_ff.job_slot);
   assign occupied = !({4'b0, s1_item_ff.job_slot} < SLOTS_CMP) || slot_valid_ff[arr_idx];
   assign arr_lvl  = ({2'b0, s1_item_ff.job_priority} >= LEVELS_CMP)
                        ? LAST_LVL : LVL_W'(s1_item_ff.job_priority);
   assign arr_svc  = (s1_item_ff.service_ticks == '0) ? SVC_W'(1)
                                                       : s1_item_ff.service_ticks;

   // Result word.
   rsp_item_type result;

   always_comb begin
      result        = '0;
      result.status = ST_OK;
      unique case (s1_item_ff.opcode)
         OP_ARRIVAL: begin
            result.status = occupied ? ST_OCCUPIED : ST_OK;
         end
         OP_TICK: begin
            if (overrun) begin
               result.status = ST_OVERRUN;
            end else if (any_ready) begin
               result.ran_valid = 1'b1;
               result.ran_slot  = JOB_SLOT_W'(pick);
               result.finished  = done;
               if (done) begin
                  result.response_ticks   = resp_val;
                  result.turnaround_ticks = turn_val;
                  result.wait_ticks       = wait_val;
               end
            end
         end
      endcase
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_item_in  = s2_item_ff;
      if (advance) begin
         s2_valid_in = s1_valid_ff;
         s2_item_in  = result;
      end
   end

   // Next state of the slot table and the clock.
   always_comb begin
      time_in         = time_ff;
      slot_valid_in   = slot_valid_ff;
      slot_started_in = slot_started_ff;
      slot_level_in   = slot_level_ff;
      slot_remain_in  = slot_remain_ff;
      slot_service_in = slot_service_ff;
      slot_arrival_in = slot_arrival_ff;
      slot_start_in   = slot_start_ff;
      level_ptr_in    = level_ptr_ff;
      if (fire) begin
         if (!is_tick) begin
            if (!occupied) begin
               slot_valid_in[arr_idx]   = 1'b1;
               slot_started_in[arr_idx] = 1'b0;
               slot_level_in[arr_idx]   = arr_lvl;
               slot_remain_in[arr_idx]  = arr_svc;
               slot_service_in[arr_idx] = arr_svc;
               slot_arrival_in[arr_idx] = time_ff;
            end
         end else if (!overrun) begin
            time_in = time_next;
            if (any_ready) begin
               level_ptr_in[pick_lvl] = pick_next;
               slot_started_in[pick]  = 1'b1;
               slot_start_in[pick]    = start_val;
               slot_remain_in[pick]   = rem_next;
               if (done) begin
                  slot_valid_in[pick]   = 1'b0;
                  slot_started_in[pick] = 1'b0;
               end
            end
         end
      end
   end

   // Register port.
   logic csr_write;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      if (csr_write && (csr_paddr[CSR_ADDR_W-1:CSR_IDX_LSB] == REG_TIME_LIMIT)) begin
         limit_in = csr_pwdata[TIME_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:CSR_IDX_LSB] == REG_TIME_LIMIT)
                          ? CSR_DATA_W'(limit_ff) : '0;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         time_ff         <= '0;
         limit_ff        <= TIME_LIMIT_RESET;
         slot_valid_ff   <= '0;
         slot_started_ff <= '0;
         for (int l = 0; l < LEVELS; l++) begin
            level_ptr_ff[l] <= '0;
         end
      end else begin
         s1_valid_ff     <= s1_valid_in;
         s2_valid_ff     <= s2_valid_in;
         time_ff         <= time_in;
         limit_ff        <= limit_in;
         slot_valid_ff   <= slot_valid_in;
         slot_started_ff <= slot_started_in;
         level_ptr_ff    <= level_ptr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_item_ff      <= s1_item_in;
      s2_item_ff      <= s2_item_in;
      slot_level_ff   <= slot_level_in;
      slot_remain_ff  <= slot_remain_in;
      slot_service_ff <= slot_service_in;
      slot_arrival_ff <= slot_arrival_in;
      slot_start_ff   <= slot_start_in;
   end

   // Response ports.
   assign rsp_ch.valid            = s2_valid_ff;
   assign rsp_ch.status           = s2_item_ff.status;
   assign rsp_ch.ran_valid        = s2_item_ff.ran_valid;
   assign rsp_ch.ran_slot         = s2_item_ff.ran_slot;
   assign rsp_ch.finished         = s2_item_ff.finished;
   assign rsp_ch.response_ticks   = s2_item_ff.response_ticks;
   assign rsp_ch.turnaround_ticks = s2_item_ff.turnaround_ticks;
   assign rsp_ch.wait_ticks       = s2_item_ff.wait_ticks;

   // Checks.
   `PRRS_ASSERT_NOW(a_finish_implies_run, rsp_ch.valid && rsp_ch.finished, rsp_ch.ran_valid)
   `PRRS_ASSERT_NOW(a_empty_input_ready, !s1_valid_ff, req_ch.ready)
   `PRRS_ASSERT_NEXT(a_tick_advances_time, fire && is_tick && !overrun, time_ff == $past(time_next))
   `PRRS_ASSERT_NEXT(a_done_frees_slot, fire && is_tick && !overrun && any_ready && done, !slot_valid_ff[$past(pick)])

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import prrs_pkg::*;

   localparam int NUM_SLOTS    = SLOTS_DEF;
   localparam int NUM_LEVELS   = LEVELS_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;
   localparam int SETTLE_TICKS = 6;

   typedef enum {ROW_FIXED, ROW_PREDICTED, ROW_LIMIT} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_item_type beat;
      rsp_item_type fixed_rsp;
      logic [TIME_W-1:0] limit;
   } row_type;

   logic clock;
   logic reset;

   prrs_req_if req_ch();
   prrs_rsp_if rsp_ch();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   priority_round_robin_scheduler_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Scheduler mirror: slot table, round-robin pointers, clock of ticks and limit.
   logic [TIME_W-1:0]     sched_time;
   logic [TIME_W-1:0]     limit_reg;
   logic                  job_live    [NUM_SLOTS];
   logic [PRIO_W-1:0]     job_level   [NUM_SLOTS];
   logic [SVC_W-1:0]      job_left    [NUM_SLOTS];
   logic [SVC_W-1:0]      job_len     [NUM_SLOTS];
   logic [TIME_W-1:0]     job_arrived [NUM_SLOTS];
   logic [TIME_W-1:0]     job_began   [NUM_SLOTS];
   logic                  job_has_run [NUM_SLOTS];
   logic [JOB_SLOT_W-1:0] rr_next     [NUM_LEVELS];

   rsp_item_type pending_results[$];

   int send_gap_pct;
   int rcv_gap_pct;
   int hold_request;
   int hold_left;
   int cycle_count;
   int fail_count;
   int beats_in;
   int results_seen;
   int jobs_done;
   int overruns;
   int rejects;

   rsp_item_type got_rsp;
   rsp_item_type want_rsp;

   // Clock.
   initial begin
      clock = 1'b0;
   end

   always begin
      #6 clock = ~clock;
   end

   // Cycle counter with a hard stop.
   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Apply one beat to the mirror and return the result it should produce.
   function automatic rsp_item_type schedule_step(req_item_type it);
      rsp_item_type r;
      int pick;
      logic [JOB_SLOT_W-1:0] s;
      logic [TIME_W-1:0] now;
      r = '0;
      r.status = ST_OK;
      if (it.opcode == OP_ARRIVAL) begin
         if (job_live[it.job_slot]) begin
            r.status = ST_OCCUPIED;
            rejects++;
            return r;
         end
         job_live[it.job_slot]    = 1'b1;
         job_level[it.job_slot]   = it.job_priority;
         // A job of zero length still needs one tick.
         job_left[it.job_slot]    = (it.service_ticks == '0) ? SVC_W'(1) : it.service_ticks;
         job_len[it.job_slot]     = job_left[it.job_slot];
         job_arrived[it.job_slot] = sched_time;
         job_has_run[it.job_slot] = 1'b0;
         return r;
      end
      if (sched_time > limit_reg) begin
         r.status = ST_OVERRUN;
         overruns++;
         return r;
      end
      // Lowest-numbered level first, rotating search inside the level.
      pick = -1;
      for (int lv = 0; lv < NUM_LEVELS; lv++) begin
         for (int k = 0; k < NUM_SLOTS; k++) begin
            s = rr_next[lv] + JOB_SLOT_W'(k);
            if (pick < 0 && job_live[s] && job_level[s] == PRIO_W'(lv)) begin
               pick = int'(s);
               rr_next[lv] = s + JOB_SLOT_W'(1);
            end
         end
      end
      now = sched_time;
      sched_time = sched_time + TIME_W'(1);
      if (pick < 0) begin
         return r;
      end
      r.ran_valid = 1'b1;
      r.ran_slot  = JOB_SLOT_W'(pick);
      if (!job_has_run[pick]) begin
         job_has_run[pick] = 1'b1;
         job_began[pick]   = now;
      end
      job_left[pick] = job_left[pick] - SVC_W'(1);
      if (job_left[pick] == '0) begin
         job_live[pick]     = 1'b0;
         job_has_run[pick]  = 1'b0;
         r.finished         = 1'b1;
         r.response_ticks   = job_began[pick] - job_arrived[pick];
         r.turnaround_ticks = sched_time - job_arrived[pick];
         r.wait_ticks       = r.turnaround_ticks - TIME_W'(job_len[pick]);
         jobs_done++;
      end
      return r;
   endfunction

   function automatic req_item_type arrive(int slot, int prio, int svc);
      req_item_type it;
      it.opcode        = OP_ARRIVAL;
      it.job_slot      = JOB_SLOT_W'(slot);
      it.job_priority  = PRIO_W'(prio);
      it.service_ticks = SVC_W'(svc);
      return it;
   endfunction

   function automatic req_item_type tick();
      req_item_type it;
      it = '0;
      it.opcode = OP_TICK;
      return it;
   endfunction

   function automatic rsp_item_type res(status_type st, int rv, int slot, int fin,
                                        int resp, int turn, int wt);
      rsp_item_type r;
      r.status           = st;
      r.ran_valid        = rv[0];
      r.ran_slot         = JOB_SLOT_W'(slot);
      r.finished         = fin[0];
      r.response_ticks   = TIME_W'(resp);
      r.turnaround_ticks = TIME_W'(turn);
      r.wait_ticks       = TIME_W'(wt);
      return r;
   endfunction

   function automatic row_type fixed_row(req_item_type it, rsp_item_type r);
      row_type row;
      row.kind = ROW_FIXED;
      row.beat = it;
      row.fixed_rsp = r;
      row.limit = '0;
      return row;
   endfunction

   function automatic row_type predicted_row(req_item_type it);
      row_type row;
      row.kind = ROW_PREDICTED;
      row.beat = it;
      row.fixed_rsp = '0;
      row.limit = '0;
      return row;
   endfunction

   function automatic row_type limit_row(int v);
      row_type row;
      row.kind = ROW_LIMIT;
      row.beat = '0;
      row.fixed_rsp = '0;
      row.limit = TIME_W'(v);
      return row;
   endfunction

   // Random beat: mostly ticks and arrivals into free slots, some into any slot.
   function automatic req_item_type random_job_beat();
      req_item_type it;
      int roll;
      int free_slots[$];
      it.opcode        = OP_TICK;
      it.job_slot      = JOB_SLOT_W'($urandom);
      it.job_priority  = PRIO_W'($urandom);
      if ($urandom_range(0, 99) < 80) begin
         it.service_ticks = SVC_W'($urandom_range(0, 3));
      end else begin
         it.service_ticks = SVC_W'($urandom_range(0, 15));
      end
      roll = $urandom_range(0, 99);
      if (roll >= 70) begin
         it.opcode = OP_ARRIVAL;
         if (roll < 92) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!job_live[i]) begin
                  free_slots.push_back(i);
               end
            end
            if (free_slots.size() > 0) begin
               it.job_slot = JOB_SLOT_W'(free_slots[$urandom_range(0, free_slots.size() - 1)]);
            end
         end
      end
      return it;
   endfunction

   // Offer one beat, with an optional gap first; predict once it is taken.
   task automatic send_beat(req_item_type it, bit use_fixed, rsp_item_type fixed_rsp);
      rsp_item_type predicted;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= it.opcode;
      req_ch.job_slot      <= it.job_slot;
      req_ch.job_priority  <= it.job_priority;
      req_ch.service_ticks <= it.service_ticks;
      do begin
         @(posedge clock);
      end while (req_ch.ready !== 1'b1);
      predicted = schedule_step(it);
      beats_in++;
      pending_results.push_back(use_fixed ? fixed_rsp : predicted);
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         send_beat(random_job_beat(), 1'b0, '0);
      end
   endtask

   // Stop offering beats until every result is back, then let the pipe settle.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Write the time limit while idle, then read it back.
   task automatic program_limit(logic [TIME_W-1:0] v);
      logic [CSR_ADDR_W-1:0] addr;
      addr = {REG_TIME_LIMIT, {CSR_IDX_LSB{1'b0}}};
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= CSR_DATA_W'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      limit_reg = v;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(v)) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS) begin
            $display("Time limit read back %0h, wrote %0h.", csr_prdata, v);
         end
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic show_rsp(string tag, rsp_item_type r);
      $display("   %s: status=%0d ran=%0d slot=%0d fin=%0d resp=%0d turn=%0d wait=%0d",
               tag, r.status, r.ran_valid, r.ran_slot, r.finished,
               r.response_ticks, r.turnaround_ticks, r.wait_ticks);
   endtask

   // Result side: random stalls, with a long hold-off on request.
   initial begin
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_gap_pct);
         end
      end
   end

   // Compare every result beat with the oldest prediction.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got_rsp.status           = status_type'(rsp_ch.status);
         got_rsp.ran_valid        = rsp_ch.ran_valid;
         got_rsp.ran_slot         = rsp_ch.ran_slot;
         got_rsp.finished         = rsp_ch.finished;
         got_rsp.response_ticks   = rsp_ch.response_ticks;
         got_rsp.turnaround_ticks = rsp_ch.turnaround_ticks;
         got_rsp.wait_ticks       = rsp_ch.wait_ticks;
         results_seen++;
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
               $display("Result beat at cycle %0d with nothing expected.", cycle_count);
               show_rsp("actual  ", got_rsp);
            end
         end else begin
            want_rsp = pending_results.pop_front();
            if (got_rsp.status !== want_rsp.status ||
                got_rsp.ran_valid !== want_rsp.ran_valid ||
                got_rsp.ran_slot !== want_rsp.ran_slot ||
                got_rsp.finished !== want_rsp.finished ||
                got_rsp.response_ticks !== want_rsp.response_ticks ||
                got_rsp.turnaround_ticks !== want_rsp.turnaround_ticks ||
                got_rsp.wait_ticks !== want_rsp.wait_ticks) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("Mismatch on result %0d at cycle %0d.", results_seen, cycle_count);
                  show_rsp("expected", want_rsp);
                  show_rsp("actual  ", got_rsp);
               end
            end
         end
      end
   end

   // Main sequence.
   initial begin
      row_type rows[$];

      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.opcode = OP_ARRIVAL;
      req_ch.job_slot      = '0;
      req_ch.job_priority  = '0;
      req_ch.service_ticks = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      send_gap_pct  = 28;
      rcv_gap_pct   = 52;
      hold_request  = 0;
      fail_count    = 0;
      beats_in      = 0;
      results_seen  = 0;
      jobs_done     = 0;
      overruns      = 0;
      rejects       = 0;
      sched_time    = '0;
      limit_reg     = TIME_LIMIT_RESET;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         job_live[i]    = 1'b0;
         job_has_run[i] = 1'b0;
      end
      for (int i = 0; i < NUM_LEVELS; i++) begin
         rr_next[i] = '0;
      end

      // Directed rows: idle tick, zero length, occupied slot, extremes,
      // round robin, preemption, limit boundary and overrun.
      rows.push_back(fixed_row(tick(), res(ST_OK, 0, 0, 0, 0, 0, 0)));
      rows.push_back(fixed_row(arrive(0, 0, 0), res(ST_OK, 0, 0, 0, 0, 0, 0)));
      rows.push_back(fixed_row(arrive(0, 3, 15), res(ST_OCCUPIED, 0, 0, 0, 0, 0, 0)));
      rows.push_back(fixed_row(tick(), res(ST_OK, 1, 0, 1, 0, 1, 0)));
      rows.push_back(fixed_row(arrive(15, 3, 15), res(ST_OK, 0, 0, 0, 0, 0, 0)));
      rows.push_back(fixed_row(arrive(7, 3, 2), res(ST_OK, 0, 0, 0, 0, 0, 0)));
      rows.push_back(fixed_row(arrive(3, 1, 1), res(ST_OK, 0, 0, 0, 0, 0, 0)));
      rows.push_back(predicted_row(tick()));
      rows.push_back(predicted_row(tick()));
      rows.push_back(predicted_row(tick()));
      rows.push_back(predicted_row(tick()));
      rows.push_back(fixed_row(arrive(8, 0, 3), res(ST_OK, 0, 0, 0, 0, 0, 0)));
      rows.push_back(predicted_row(tick()));
      rows.push_back(fixed_row(arrive(9, 0, 1), res(ST_OK, 0, 0, 0, 0, 0, 0)));
      rows.push_back(predicted_row(tick()));
      rows.push_back(predicted_row(tick()));
      rows.push_back(predicted_row(tick()));
      rows.push_back(fixed_row(arrive(15, 0, 1), res(ST_OCCUPIED, 0, 0, 0, 0, 0, 0)));
      rows.push_back(fixed_row(arrive(2, 2, 8), res(ST_OK, 0, 0, 0, 0, 0, 0)));
      rows.push_back(limit_row(10));
      rows.push_back(predicted_row(tick()));
      rows.push_back(fixed_row(tick(), res(ST_OVERRUN, 0, 0, 0, 0, 0, 0)));
      rows.push_back(fixed_row(arrive(4, 0, 4), res(ST_OK, 0, 0, 0, 0, 0, 0)));
      rows.push_back(fixed_row(tick(), res(ST_OVERRUN, 0, 0, 0, 0, 0, 0)));
      rows.push_back(limit_row(16'hFFFF));
      rows.push_back(predicted_row(tick()));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         case (rows[i].kind)
            ROW_LIMIT: begin
               program_limit(rows[i].limit);
            end
            ROW_FIXED: begin
               send_beat(rows[i].beat, 1'b1, rows[i].fixed_rsp);
            end
            default: begin
               send_beat(rows[i].beat, 1'b0, '0);
            end
         endcase
      end

      // Unlimited time; a full drain, then a long result stall under load.
      run_random(250);
      drain_results();
      hold_request = 200;
      run_random(250);

      // Stall roles swapped; the limit falls inside the phase.
      send_gap_pct = 52;
      rcv_gap_pct  = 28;
      program_limit(sched_time + TIME_W'($urandom_range(60, 200)));
      run_random(300);

      // No stalls from here on; zero limit makes every tick an overrun.
      send_gap_pct = 0;
      rcv_gap_pct  = 0;
      program_limit('0);
      run_random(100);
      program_limit(sched_time + TIME_W'($urandom_range(100, 250)));
      run_random(350);

      // Widest limit, so every level keeps running with live jobs.
      program_limit(16'hFFFF);
      run_random(200);

      program_limit(TIME_W'($urandom_range(0, 65535)));
      run_random(150);

      drain_results();
      $display("Sent %0d beats and checked %0d results: %0d jobs completed.",
               beats_in, results_seen, jobs_done);
      $display("Saw %0d rejected arrivals and %0d overruns.", rejects, overruns);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
